/* design/refcounted_block_pool_allocator_assert.svh */
// ----------------------------------------------------------------------------
// refcounted block pool allocator assertion macros
// same-cycle and next-cycle implication checks, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define RBPA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbpa assertion failed");
`define RBPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbpa assertion failed");
`else
`define RBPA_ASSERT_SAME(label, clk, rst, ante, cons)
`define RBPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/rbpa_pkg.sv */
// ----------------------------------------------------------------------------
// rbpa_pkg
// shared widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package rbpa_pkg;

  localparam int POOL_BLOCKS_DEF = 64;
  localparam int BLOCK_SLOTS_DEF = 16;

  localparam int OPCODE_W   = 4;
  localparam int BLOCK_W    = 6;
  localparam int SLOT_W     = 4;
  localparam int TOKEN_W    = 32;
  localparam int COUNT_W    = 5;
  localparam int STATUS_W   = 3;
  localparam int FREE_W     = 7;
  localparam int BIU_W      = 7;
  localparam int TPB_W      = 5;
  localparam int REF_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [REF_W-1:0] REF_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKENS_PER_BLOCK = 2'd1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC   = 4'd0,
    OP_FREE    = 4'd1,
    OP_INCREF  = 4'd2,
    OP_READREF = 4'd3,
    OP_WRTOK   = 4'd4,
    OP_RDTOK   = 4'd5,
    OP_RDCOUNT = 4'd6,
    OP_WRCOUNT = 4'd7,
    OP_CLEAR   = 4'd8,
    OP_COPY    = 4'd9,
    OP_APPEND  = 4'd10,
    OP_QUERY   = 4'd11
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_BAD_BLOCK    = 3'd2,
    ST_BAD_SLOT     = 3'd3,
    ST_ALREADY_FREE = 3'd4,
    ST_FULL         = 3'd5,
    ST_BAD_COUNT    = 3'd6
  } status_t;

  typedef struct packed {
    logic accept;
    logic commit;
    logic wipe;
    logic copy;
    logic init;
  } rbpa_cmd_t;

  typedef struct packed {
    logic out_free;
    logic need_wipe;
    logic need_copy;
    logic wipe_done;
    logic copy_done;
    logic init_done;
  } rbpa_sts_t;

endpackage

`default_nettype wire

/* design/refcounted_block_pool_allocator.sv */
// ----------------------------------------------------------------------------
// refcounted_block_pool_allocator
// Reference-counted pool of fixed-size token blocks with a free stack. One
// operation is taken per transfer and gives one result. Most operations read
// the count, stack and token memories when accepted, then execute and
// register the result once the output register is free. Alloc, free down to
// zero and clear then wipe the block through the single token memory write
// port; copy streams the source block through it into the target. A finished
// result waits in the output register while the next operation is accepted.
// After reset and after each write of blocks_in_use an init sweep over all
// POOL_BLOCKS * BLOCK_SLOTS token slots clears the pool, and no operation is
// accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
`include "refcounted_block_pool_allocator_assert.svh"

module refcounted_block_pool_allocator #(
  parameter int POOL_BLOCKS = rbpa_pkg::POOL_BLOCKS_DEF,
  parameter int BLOCK_SLOTS = rbpa_pkg::BLOCK_SLOTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [rbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [rbpa_pkg::OPCODE_W-1:0]       opcode,
  input  wire logic [rbpa_pkg::BLOCK_W-1:0]        block,
  input  wire logic [rbpa_pkg::BLOCK_W-1:0]        source_block,
  input  wire logic [rbpa_pkg::SLOT_W-1:0]         slot,
  input  wire logic signed [rbpa_pkg::TOKEN_W-1:0] token,
  input  wire logic [rbpa_pkg::COUNT_W-1:0]        count,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [rbpa_pkg::STATUS_W-1:0]            status,
  output logic [rbpa_pkg::BLOCK_W-1:0]             allocated_block,
  output logic signed [rbpa_pkg::TOKEN_W-1:0]      read_value,
  output logic [rbpa_pkg::FREE_W-1:0]              free_blocks
);
  import rbpa_pkg::*;

  rbpa_cmd_t cmd;
  rbpa_sts_t sts;
  logic      reinit;
  logic [4:0] cmd_bits;

  rbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .reinit   (reinit),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  rbpa_dp #(
    .POOL_BLOCKS (POOL_BLOCKS),
    .BLOCK_SLOTS (BLOCK_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .reinit          (reinit),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .opcode          (opcode),
    .block           (block),
    .source_block    (source_block),
    .slot            (slot),
    .token           (token),
    .count           (count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .allocated_block (allocated_block),
    .read_value      (read_value),
    .free_blocks     (free_blocks)
  );

  assign cmd_bits = cmd;

  `RBPA_ASSERT_SAME(a_cmd_onehot, clk, rst, 1'b1, $onehot0(cmd_bits))
  `RBPA_ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_valid && !in_stall, in_stall)
  `RBPA_ASSERT_NEXT(a_result_after_commit, clk, rst, cmd.commit, out_valid)

endmodule

`default_nettype wire

/* design/rbpa_ctrl.sv */
// ----------------------------------------------------------------------------
// rbpa_ctrl
// sequencer: accept, execute, block wipe, block copy and pool init sweep
// ----------------------------------------------------------------------------
`default_nettype none

module rbpa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                reinit,
  input  wire rbpa_pkg::rbpa_sts_t sts,
  output rbpa_pkg::rbpa_cmd_t      cmd,
  output logic                     in_stall
);
  import rbpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_WIPE = 5'b00100,
    S_COPY = 5'b01000,
    S_INIT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          if (sts.need_wipe) begin
            state_next = S_WIPE;
          end else if (sts.need_copy) begin
            state_next = S_COPY;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_WIPE: begin
        cmd.wipe = 1'b1;
        if (sts.wipe_done) state_next = S_IDLE;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_done) state_next = S_IDLE;
      end
      S_INIT: begin
        cmd.init = 1'b1;
        if (sts.init_done) state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
    if (reinit) begin
      cmd        = '0;
      state_next = S_INIT;
    end
  end

  assign in_stall = (state != S_IDLE) || reinit;

endmodule

`default_nettype wire

/* design/rbpa_dp.sv */
// ----------------------------------------------------------------------------
// rbpa_dp
// pool datapath: free stack, reference and fill counts, token store, result
// ----------------------------------------------------------------------------
`default_nettype none

module rbpa_dp #(
  parameter int POOL_BLOCKS = rbpa_pkg::POOL_BLOCKS_DEF,
  parameter int BLOCK_SLOTS = rbpa_pkg::BLOCK_SLOTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire rbpa_pkg::rbpa_cmd_t                 cmd,
  output rbpa_pkg::rbpa_sts_t                      sts,
  output logic                                     reinit,
  input  wire logic                                cfg_write,
  input  wire logic [rbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [rbpa_pkg::OPCODE_W-1:0]       opcode,
  input  wire logic [rbpa_pkg::BLOCK_W-1:0]        block,
  input  wire logic [rbpa_pkg::BLOCK_W-1:0]        source_block,
  input  wire logic [rbpa_pkg::SLOT_W-1:0]         slot,
  input  wire logic signed [rbpa_pkg::TOKEN_W-1:0] token,
  input  wire logic [rbpa_pkg::COUNT_W-1:0]        count,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [rbpa_pkg::STATUS_W-1:0]            status,
  output logic [rbpa_pkg::BLOCK_W-1:0]             allocated_block,
  output logic signed [rbpa_pkg::TOKEN_W-1:0]      read_value,
  output logic [rbpa_pkg::FREE_W-1:0]              free_blocks
);
  import rbpa_pkg::*;

  localparam int BID_W   = $clog2(POOL_BLOCKS);
  localparam int SC_W    = $clog2(BLOCK_SLOTS + 1);
  localparam int DEPTH   = POOL_BLOCKS * BLOCK_SLOTS;
  localparam int TA_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FT_W    = $clog2(POOL_BLOCKS + 1);
  localparam int BIU_RST = (POOL_BLOCKS < 64) ? POOL_BLOCKS : 64;
  localparam int TPB_RST = (BLOCK_SLOTS < 16) ? BLOCK_SLOTS : 16;

  function automatic logic [TA_W-1:0] taddr(input logic [BID_W-1:0] b,
                                            input logic [SC_W-1:0] s);
    return TA_W'(b * BLOCK_SLOTS + s);
  endfunction

  // storage
  logic [TOKEN_W-1:0] tok_mem  [DEPTH];
  logic [REF_W-1:0]   ref_mem  [POOL_BLOCKS];
  logic [COUNT_W-1:0] fill_mem [POOL_BLOCKS];
  logic [BID_W-1:0]   fl_mem   [POOL_BLOCKS];

  // configuration and control registers
  logic [BIU_W-1:0] biu;
  logic [TPB_W-1:0] tpb;
  logic [FT_W-1:0]  free_top;
  logic [SC_W-1:0]  slot_cnt;
  logic [BID_W-1:0] sw_blk;

  // held operation and read data
  logic [OPCODE_W-1:0] op_r;
  logic [BLOCK_W-1:0]  blk_r;
  logic [BLOCK_W-1:0]  src_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [TOKEN_W-1:0]  tok_r;
  logic [COUNT_W-1:0]  cnt_r;
  logic [BID_W-1:0]    wblk;
  logic [REF_W-1:0]    ref_rd;
  logic [COUNT_W-1:0]  fillb_rd;
  logic [COUNT_W-1:0]  fills_rd;
  logic [BID_W-1:0]    fl_rd;
  logic [TOKEN_W-1:0]  tok_rd;

  logic [BIU_W-1:0] biu_cfg;
  logic [TPB_W-1:0] tpb_cfg;

  always_comb begin
    biu_cfg = cfg_data[BIU_W-1:0];
    if (biu_cfg == '0) begin
      biu_cfg = BIU_W'(1);
    end else if (biu_cfg > POOL_BLOCKS) begin
      biu_cfg = BIU_W'(POOL_BLOCKS);
    end
    tpb_cfg = cfg_data[TPB_W-1:0];
    if (tpb_cfg == '0) begin
      tpb_cfg = TPB_W'(1);
    end else if (tpb_cfg > BLOCK_SLOTS) begin
      tpb_cfg = TPB_W'(BLOCK_SLOTS);
    end
  end

  assign reinit = cfg_write && (cfg_index == CFG_BLOCKS_IN_USE);

  // operation decode
  logic [BID_W-1:0]   b_id, s_id;
  logic               bad_blk;
  status_t            st;
  logic [BID_W-1:0]   given;
  logic [TOKEN_W-1:0] val;
  logic [FT_W-1:0]    ft_next;
  logic               ref_we, fill_we, tok_we_x, push, need_wipe, need_copy;
  logic [BID_W-1:0]   ref_wa, fill_wa, wblk_n;
  logic [REF_W-1:0]   ref_wd;
  logic [COUNT_W-1:0] fill_wd;
  logic [TA_W-1:0]    tok_wa_x;
  logic [TOKEN_W-1:0] tok_wd_x;

  assign b_id = BID_W'(blk_r);
  assign s_id = BID_W'(src_r);

  always_comb begin
    bad_blk = (blk_r >= biu) || ((op_r == OP_COPY) && (src_r >= biu));
    st        = ST_OK;
    given     = '0;
    val       = '0;
    ft_next   = free_top;
    ref_we    = 1'b0;
    ref_wa    = b_id;
    ref_wd    = ref_rd;
    fill_we   = 1'b0;
    fill_wa   = b_id;
    fill_wd   = '0;
    tok_we_x  = 1'b0;
    tok_wa_x  = taddr(b_id, SC_W'(slot_r));
    tok_wd_x  = tok_r;
    push      = 1'b0;
    need_wipe = 1'b0;
    need_copy = 1'b0;
    wblk_n    = b_id;
    if ((op_r >= OP_FREE) && (op_r <= OP_APPEND) && bad_blk) begin
      st = ST_BAD_BLOCK;
    end else begin
      case (opcode_t'(op_r))
        OP_ALLOC: begin
          if (free_top == '0) begin
            st = ST_EMPTY;
          end else begin
            ft_next   = free_top - 1'b1;
            given     = fl_rd;
            ref_we    = 1'b1;
            ref_wa    = fl_rd;
            ref_wd    = REF_W'(1);
            fill_we   = 1'b1;
            fill_wa   = fl_rd;
            need_wipe = 1'b1;
            wblk_n    = fl_rd;
          end
        end
        OP_FREE: begin
          if (ref_rd == '0) begin
            st = ST_ALREADY_FREE;
          end else begin
            ref_we = 1'b1;
            ref_wd = ref_rd - 1'b1;
            if (ref_rd == REF_W'(1)) begin
              fill_we   = 1'b1;
              need_wipe = 1'b1;
              if (free_top < POOL_BLOCKS) begin
                push    = 1'b1;
                ft_next = free_top + 1'b1;
              end
            end
          end
        end
        OP_INCREF: begin
          if (ref_rd == '0) begin
            st = ST_ALREADY_FREE;
          end else if (ref_rd != REF_MAX) begin
            ref_we = 1'b1;
            ref_wd = ref_rd + 1'b1;
          end
        end
        OP_READREF: begin
          val = TOKEN_W'(ref_rd);
        end
        OP_WRTOK: begin
          if (slot_r >= tpb) begin
            st = ST_BAD_SLOT;
          end else begin
            tok_we_x = 1'b1;
          end
        end
        OP_RDTOK: begin
          if (slot_r >= tpb) begin
            st = ST_BAD_SLOT;
          end else begin
            val = tok_rd;
          end
        end
        OP_RDCOUNT: begin
          val = TOKEN_W'(fillb_rd);
        end
        OP_WRCOUNT: begin
          if (cnt_r > tpb) begin
            st = ST_BAD_COUNT;
          end else begin
            fill_we = 1'b1;
            fill_wd = cnt_r;
          end
        end
        OP_CLEAR: begin
          fill_we   = 1'b1;
          need_wipe = 1'b1;
        end
        OP_COPY: begin
          fill_we   = 1'b1;
          fill_wd   = fills_rd;
          need_copy = 1'b1;
        end
        OP_APPEND: begin
          if (fillb_rd >= tpb) begin
            st = ST_FULL;
          end else begin
            tok_we_x = 1'b1;
            tok_wa_x = taddr(b_id, SC_W'(fillb_rd));
            fill_we  = 1'b1;
            fill_wd  = fillb_rd + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // status to the controller
  logic wipe_last;
  assign wipe_last = (slot_cnt == SC_W'(BLOCK_SLOTS - 1));
  assign sts = {(!out_valid || !out_stall),
                need_wipe,
                need_copy,
                wipe_last,
                (slot_cnt == SC_W'(BLOCK_SLOTS)),
                (wipe_last && (sw_blk == BID_W'(POOL_BLOCKS - 1)))};

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      biu       <= BIU_W'(BIU_RST);
      tpb       <= TPB_W'(TPB_RST);
      free_top  <= FT_W'(BIU_RST);
      slot_cnt  <= '0;
      sw_blk    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (reinit) begin
        biu      <= biu_cfg;
        free_top <= FT_W'(biu_cfg);
        slot_cnt <= '0;
        sw_blk   <= '0;
      end else begin
        if (cfg_write && (cfg_index == CFG_TOKENS_PER_BLOCK)) tpb <= tpb_cfg;
        if (cmd.commit) begin
          free_top <= ft_next;
          slot_cnt <= '0;
        end else if (cmd.wipe || cmd.copy) begin
          slot_cnt <= slot_cnt + 1'b1;
        end else if (cmd.init) begin
          if (wipe_last) begin
            slot_cnt <= '0;
            sw_blk   <= sw_blk + 1'b1;
          end else begin
            slot_cnt <= slot_cnt + 1'b1;
          end
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // held operation, result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= opcode;
      blk_r  <= block;
      src_r  <= source_block;
      slot_r <= slot;
      tok_r  <= token;
      cnt_r  <= count;
    end
    if (cmd.commit) begin
      wblk            <= wblk_n;
      status          <= st;
      allocated_block <= BLOCK_W'(given);
      read_value      <= val;
      free_blocks     <= FREE_W'(ft_next);
    end
  end

  // count and free stack memories
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ref_rd   <= ref_mem[BID_W'(block)];
      fillb_rd <= fill_mem[BID_W'(block)];
      fills_rd <= fill_mem[BID_W'(source_block)];
      fl_rd    <= fl_mem[BID_W'(free_top - 1'b1)];
    end
    if (cmd.commit && ref_we) begin
      ref_mem[ref_wa] <= ref_wd;
    end else if (cmd.init) begin
      ref_mem[sw_blk] <= '0;
    end
    if (cmd.commit && fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end else if (cmd.init) begin
      fill_mem[sw_blk] <= '0;
    end
    if (cmd.commit && push) begin
      fl_mem[BID_W'(free_top)] <= b_id;
    end else if (cmd.init) begin
      fl_mem[sw_blk] <= sw_blk;
    end
  end

  // token store
  logic               tok_we, tok_re;
  logic [TA_W-1:0]    tok_wa, tok_ra;
  logic [TOKEN_W-1:0] tok_wd;

  always_comb begin
    tok_we = 1'b0;
    tok_wa = tok_wa_x;
    tok_wd = tok_wd_x;
    if (cmd.commit) begin
      tok_we = tok_we_x;
    end else if (cmd.wipe) begin
      tok_we = 1'b1;
      tok_wa = taddr(wblk, slot_cnt);
      tok_wd = '0;
    end else if (cmd.copy) begin
      tok_we = (slot_cnt != '0);
      tok_wa = taddr(b_id, slot_cnt - 1'b1);
      tok_wd = tok_rd;
    end else if (cmd.init) begin
      tok_we = 1'b1;
      tok_wa = taddr(sw_blk, slot_cnt);
      tok_wd = '0;
    end
    tok_re = cmd.accept || (cmd.copy && (slot_cnt < BLOCK_SLOTS));
    tok_ra = cmd.copy ? taddr(s_id, slot_cnt) : taddr(BID_W'(block), SC_W'(slot));
  end

  always_ff @(posedge clk) begin
    if (tok_we) tok_mem[tok_wa] <= tok_wd;
    if (tok_re) tok_rd <= tok_mem[tok_ra];
  end

endmodule

`default_nettype wire

/* sim/tb_refcounted_block_pool_allocator.sv */
// ----------------------------------------------------------------------------
// tb_refcounted_block_pool_allocator
// Drives allocator operations over the valid/stall handshake and checks each
// result against a predictor of the block pool: free stack, reference counts,
// fill counts and token store. A short directed sequence is followed by
// random phases under several pool sizes and capacities, with random idling
// on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_refcounted_block_pool_allocator;
  import rbpa_pkg::*;

  typedef struct packed {
    logic [OPCODE_W-1:0]       op;
    logic [BLOCK_W-1:0]        blk;
    logic [BLOCK_W-1:0]        src;
    logic [SLOT_W-1:0]         slt;
    logic signed [TOKEN_W-1:0] tok;
    logic [COUNT_W-1:0]        cnt;
  } op_item_t;

  typedef struct packed {
    status_t                   st;
    logic [BLOCK_W-1:0]        given;
    logic signed [TOKEN_W-1:0] value;
    logic [FREE_W-1:0]         nfree;
  } op_result_t;

  localparam int NB = POOL_BLOCKS_DEF;
  localparam int BS = BLOCK_SLOTS_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OPCODE_W-1:0] opcode = '0;
  logic [BLOCK_W-1:0] block = '0;
  logic [BLOCK_W-1:0] source_block = '0;
  logic [SLOT_W-1:0] slot = '0;
  logic signed [TOKEN_W-1:0] token = '0;
  logic [COUNT_W-1:0] count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [BLOCK_W-1:0] allocated_block;
  logic signed [TOKEN_W-1:0] read_value;
  logic [FREE_W-1:0] free_blocks;

  refcounted_block_pool_allocator u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted pool state
  int unsigned pool_size, capacity;
  logic [BLOCK_W-1:0] stack_ids [NB];
  int unsigned stack_ptr;
  logic [REF_W-1:0] refs [NB];
  logic [COUNT_W-1:0] fills [NB];
  logic [TOKEN_W-1:0] tokens [NB][BS];

  op_item_t pending_ops[$];
  op_result_t expected_results[$];
  int fails = 0;
  bit calm = 0;
  bit sending = 0;

  function automatic void wipe(int b);
    for (int s = 0; s < BS; s++) tokens[b][s] = '0;
    fills[b] = '0;
  endfunction

  function automatic void init_pool();
    for (int i = 0; i < NB; i++) begin
      stack_ids[i] = BLOCK_W'(i);
      refs[i] = '0;
      wipe(i);
    end
    stack_ptr = pool_size;
  endfunction

  function automatic int unsigned clamp(int unsigned v, int unsigned hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  function automatic op_result_t pool_step(op_item_t it);
    op_result_t r;
    logic [TOKEN_W-1:0] row [BS];
    int b, f;
    r = '{st: ST_OK, given: '0, value: '0, nfree: '0};
    b = it.blk;
    if (it.op == OP_ALLOC) begin
      if (stack_ptr == 0) r.st = ST_EMPTY;
      else begin
        stack_ptr--;
        r.given = stack_ids[stack_ptr];
        refs[r.given] = REF_W'(1);
        wipe(r.given);
      end
    end else if (it.op >= OP_FREE && it.op <= OP_APPEND) begin
      if (b >= pool_size || (it.op == OP_COPY && it.src >= pool_size)) r.st = ST_BAD_BLOCK;
      else case (opcode_t'(it.op))
        OP_FREE: begin
          if (refs[b] == 0) r.st = ST_ALREADY_FREE;
          else begin
            refs[b]--;
            if (refs[b] == 0) begin
              wipe(b);
              if (stack_ptr < NB) begin
                stack_ids[stack_ptr] = BLOCK_W'(b);
                stack_ptr++;
              end
            end
          end
        end
        OP_INCREF: begin
          if (refs[b] == 0) r.st = ST_ALREADY_FREE;
          else if (refs[b] != REF_MAX) refs[b]++;
        end
        OP_READREF: r.value = refs[b];
        OP_WRTOK, OP_RDTOK: begin
          if (it.slt >= capacity) r.st = ST_BAD_SLOT;
          else if (it.op == OP_WRTOK) tokens[b][it.slt] = it.tok;
          else r.value = tokens[b][it.slt];
        end
        OP_RDCOUNT: r.value = fills[b];
        OP_WRCOUNT: begin
          if (it.cnt > capacity) r.st = ST_BAD_COUNT;
          else fills[b] = it.cnt;
        end
        OP_CLEAR: wipe(b);
        OP_COPY: begin
          for (int s = 0; s < BS; s++) row[s] = tokens[it.src][s];
          for (int s = 0; s < BS; s++) tokens[b][s] = row[s];
          fills[b] = fills[it.src];
        end
        default: begin
          f = fills[b];
          if (f >= capacity) r.st = ST_FULL;
          else begin
            tokens[b][f] = it.tok;
            fills[b] = COUNT_W'(f + 1);
          end
        end
      endcase
    end
    r.nfree = FREE_W'(stack_ptr);
    return r;
  endfunction

  function automatic op_item_t mk(logic [OPCODE_W-1:0] op, int b, int s = 0, int sl = 0,
                                  logic [TOKEN_W-1:0] t = '0, int c = 0);
    op_item_t it;
    it.op = op; it.blk = BLOCK_W'(b); it.src = BLOCK_W'(s); it.slt = SLOT_W'(sl);
    it.tok = t; it.cnt = COUNT_W'(c);
    return it;
  endfunction

  function automatic op_item_t random_op();
    op_item_t it;
    int w;
    w = $urandom_range(0, 99);
    it.op = OPCODE_W'((w < 20) ? OP_ALLOC : (w < 35) ? OP_FREE : (w < 43) ? OP_INCREF :
            (w < 48) ? OP_READREF : (w < 58) ? OP_WRTOK : (w < 68) ? OP_RDTOK :
            (w < 73) ? OP_RDCOUNT : (w < 80) ? OP_WRCOUNT : (w < 84) ? OP_CLEAR :
            (w < 89) ? OP_COPY : (w < 98) ? OP_APPEND : $urandom_range(11, 15));
    it.blk = BLOCK_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, pool_size - 1));
    it.src = BLOCK_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, pool_size - 1));
    it.slt = SLOT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, capacity - 1));
    it.tok = $urandom;
    it.cnt = COUNT_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, capacity));
    return it;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx == CFG_BLOCKS_IN_USE) begin
      pool_size = clamp(v, NB);
      init_pool();
    end else if (idx == CFG_TOKENS_PER_BLOCK) capacity = clamp(v & 7'h1f, BS);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (pending_ops.size() > 0 || sending || expected_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) pending_ops.push_back(random_op());
    drain();
  endtask

  // driver
  op_item_t cur = '0;
  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      sending = 0;
      gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(pool_step(cur));
        sending = 0;
      end
      if (!sending) begin
        if (gap > 0) gap--;
        else if (pending_ops.size() > 0) begin
          if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 5);
          else begin
            cur = pending_ops.pop_front();
            sending = 1;
          end
        end
      end
      in_valid <= sending;
      opcode <= cur.op;
      block <= cur.blk;
      source_block <= cur.src;
      slot <= cur.slt;
      token <= cur.tok;
      count <= cur.cnt;
    end
  end

  // receiver stalls, with one long hold-off once results are flowing
  int stall_left = 0, hold_left = 0, seen = 0;
  bit held = 0;
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else begin
      if (out_valid && !out_stall) seen++;
      if (!held && seen >= 200) begin
        held = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    op_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transfer status=%0d", $time, status);
        fails++;
      end else begin
        e = expected_results.pop_front();
        if (status !== e.st) begin
          $display("%0t: status exp %0d got %0d", $time, e.st, status);
          fails++;
        end
        if (allocated_block !== e.given) begin
          $display("%0t: allocated_block exp %0d got %0d", $time, e.given, allocated_block);
          fails++;
        end
        if (read_value !== e.value) begin
          $display("%0t: read_value exp %0d got %0d", $time, e.value, read_value);
          fails++;
        end
        if (free_blocks !== e.nfree) begin
          $display("%0t: free_blocks exp %0d got %0d", $time, e.nfree, free_blocks);
          fails++;
        end
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("tb_refcounted_block_pool_allocator NOT OK");
      $finish;
    end
  end

  initial begin
    pool_size = NB;
    capacity = BS;
    init_pool();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // directed
    pending_ops.push_back(mk(OP_ALLOC, 0));
    pending_ops.push_back(mk(OP_ALLOC, 63));
    pending_ops.push_back(mk(OP_INCREF, 63));
    pending_ops.push_back(mk(OP_READREF, 63));
    pending_ops.push_back(mk(OP_WRTOK, 63, 0, 15, 32'h7fffffff));
    pending_ops.push_back(mk(OP_WRTOK, 63, 0, 0, 32'h80000000));
    pending_ops.push_back(mk(OP_RDTOK, 63, 0, 15));
    pending_ops.push_back(mk(OP_RDTOK, 63, 0, 0));
    pending_ops.push_back(mk(OP_WRCOUNT, 63, 0, 0, 0, 16));
    pending_ops.push_back(mk(OP_WRCOUNT, 63, 0, 0, 0, 31));
    pending_ops.push_back(mk(OP_APPEND, 63, 0, 0, 32'h1234));
    pending_ops.push_back(mk(OP_WRCOUNT, 63, 0, 0, 0, 0));
    pending_ops.push_back(mk(OP_APPEND, 63, 0, 0, 32'hffffffff));
    pending_ops.push_back(mk(OP_RDCOUNT, 63));
    pending_ops.push_back(mk(OP_COPY, 62, 63));
    pending_ops.push_back(mk(OP_COPY, 63, 63));
    pending_ops.push_back(mk(OP_RDTOK, 62, 0, 0));
    pending_ops.push_back(mk(OP_CLEAR, 62));
    pending_ops.push_back(mk(OP_FREE, 62));
    pending_ops.push_back(mk(OP_FREE, 62));
    pending_ops.push_back(mk(OP_INCREF, 62));
    pending_ops.push_back(mk(OP_FREE, 63));
    pending_ops.push_back(mk(OP_QUERY, 0));
    pending_ops.push_back(mk(4'd15, 5));
    drain();
    write_reg(CFG_BLOCKS_IN_USE, 7'd0);
    write_reg(CFG_TOKENS_PER_BLOCK, 7'd0);
    random_phase(300);
    write_reg(CFG_BLOCKS_IN_USE, 7'd5);
    write_reg(CFG_TOKENS_PER_BLOCK, 7'd7);
    random_phase(600);
    write_reg(CFG_BLOCKS_IN_USE, 7'd127);
    write_reg(CFG_TOKENS_PER_BLOCK, 7'd31);
    random_phase(500);
    write_reg(CFG_TOKENS_PER_BLOCK, 7'd16);
    random_phase(300);
    calm = 1;
    write_reg(CFG_BLOCKS_IN_USE, 7'd3);
    write_reg(CFG_TOKENS_PER_BLOCK, 7'd2);
    random_phase(300);
    if (fails == 0) $display("tb_refcounted_block_pool_allocator OK");
    else $display("tb_refcounted_block_pool_allocator NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+design
design/rbpa_pkg.sv
design/rbpa_ctrl.sv
design/rbpa_dp.sv
design/refcounted_block_pool_allocator.sv
sim/tb_refcounted_block_pool_allocator.sv
